[rtl/grmc_pkg.sv]
// ----------------------------------------------------------------------------
// grmc_pkg
// Shared types, constants and tables for the grid ray march column unit.
// ----------------------------------------------------------------------------
`default_nettype none

package grmc_pkg;

    localparam int MAP_SIZE_DEF  = 16;
    localparam int MAX_DEPTH_DEF = 16;

    localparam int CELL_W      = 4;
    localparam int MAP_ROWS    = 16;
    localparam int MAP_COLS    = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int POS_IN_W    = 12;
    localparam int ANG_W       = 16;
    localparam int COL_W       = 8;
    localparam int FOV_W       = 16;
    localparam int SWIDTH_W    = 9;
    localparam int SHEIGHT_W   = 7;

    localparam int TRIG_W      = 18;
    localparam int Z_W         = 17;
    localparam int ATAN_W      = 14;
    localparam int ITER_W      = 4;
    localparam int CORDIC_ITERS = 14;
    localparam logic signed [TRIG_W-1:0] CORDIC_K = 18'sd9949;

    localparam int POS_W       = 26;
    localparam int CELL_SPAN   = 163840;
    localparam int VEC_W       = 14;
    localparam int MAG2_W      = 26;
    localparam int PMAG_W      = 27;
    localparam int PROD_W      = 56;
    localparam logic [29:0] COS2_Q30 = 30'd1071059706;

    localparam int DIV_NUM_W   = 24;
    localparam int DIV_DEN_W   = 11;
    localparam int DIV_CNT_W   = 5;
    localparam int ROWN_W      = 20;

    localparam int DIST_OUT_W  = 8;
    localparam int ROW_W       = 11;
    localparam int SHADE_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_0_3   = 3'd0,
        REG_MAP_4_7   = 3'd1,
        REG_MAP_8_11  = 3'd2,
        REG_MAP_12_15 = 3'd3,
        REG_FOV       = 3'd4,
        REG_WIDTH     = 3'd5,
        REG_HEIGHT    = 3'd6
    } cfg_reg_t;

    typedef enum logic [SHADE_W-1:0] {
        SHADE_BLANK  = 3'd0,
        SHADE_FULL   = 3'd1,
        SHADE_DARK   = 3'd2,
        SHADE_MEDIUM = 3'd3,
        SHADE_LIGHT  = 3'd4
    } shade_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ANGLE,
        OP_CORDIC,
        OP_MARCH_INIT,
        OP_MARCH,
        OP_EDGE_M,
        OP_EDGE_SEL,
        OP_EDGE_P,
        OP_EDGE_SQ,
        OP_EDGE_CMP,
        OP_DIV_ROW,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_ANG,
        S_ANGLE,
        S_CORDIC,
        S_MARCH_INIT,
        S_MARCH,
        S_EDGE_M,
        S_EDGE_SEL,
        S_EDGE_P,
        S_EDGE_SQ,
        S_EDGE_CMP,
        S_ROW_START,
        S_DIV_ROW,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   corner_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic cordic_last;
        logic march_stop;
        logic march_hit;
    } dp_status_t;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // cell index of an in-range track value: t / 163840, t >> 14 then / 10
    function automatic logic [CELL_W-1:0] cell_of(input logic signed [POS_W-1:0] t);
        logic [15:0] prod;
        prod = t[21:14] * 8'd205;
        return t[POS_W-1] ? '0 : prod[14:11];
    endfunction

endpackage

`default_nettype wire

[rtl/grmc_divider.sv]
// ----------------------------------------------------------------------------
// grmc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grmc_divider
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [grmc_pkg::DIV_NUM_W-1:0] numer,
    input  wire logic [grmc_pkg::DIV_DEN_W-1:0] denom,
    output logic                                done,
    output logic [grmc_pkg::DIV_NUM_W-1:0]      quotient
);
    import grmc_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = numer;
            den_next = denom;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DIV_DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/grmc_datapath.sv]
// ----------------------------------------------------------------------------
// grmc_datapath
// Configuration registers, angle, CORDIC, march, corner test and row math.
// ----------------------------------------------------------------------------
`default_nettype none

module grmc_datapath
#(
    parameter int MAP_SIZE  = grmc_pkg::MAP_SIZE_DEF,
    parameter int MAX_DEPTH = grmc_pkg::MAX_DEPTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire grmc_pkg::dp_cmd_t               cmd,
    output grmc_pkg::dp_status_t                 status,
    input  wire logic                            cfg_write,
    input  wire logic [grmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [grmc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [grmc_pkg::POS_IN_W-1:0]   player_x,
    input  wire logic [grmc_pkg::POS_IN_W-1:0]   player_y,
    input  wire logic [grmc_pkg::ANG_W-1:0]      view_angle,
    input  wire logic [grmc_pkg::COL_W-1:0]      column,
    output logic                                 done,
    output logic [grmc_pkg::DIST_OUT_W-1:0]      distance_tenths,
    output logic signed [grmc_pkg::ROW_W-1:0]    ceiling_row,
    output logic [grmc_pkg::ROW_W-1:0]           floor_row,
    output logic [grmc_pkg::SHADE_W-1:0]         wall_shade,
    output logic                                 on_edge,
    output logic                                 left_map
);
    import grmc_pkg::*;

    localparam int STEPS_MAX = 10 * MAX_DEPTH;
    localparam int DIST_W    = $clog2(STEPS_MAX + 1);
    localparam logic signed [POS_W-1:0] LIMIT_HI = POS_W'(MAP_SIZE * CELL_SPAN);
    localparam logic signed [POS_W-1:0] LIMIT_LO = -POS_W'(CELL_SPAN);

    logic [MAP_COLS-1:0]  map_reg [MAP_ROWS];
    logic [FOV_W-1:0]     fov_reg;
    logic [SWIDTH_W-1:0]  width_reg;
    logic [SHEIGHT_W-1:0] height_reg;

    logic [POS_IN_W-1:0]        px_reg, py_reg;
    logic [ANG_W-1:0]           view_reg;
    logic signed [TRIG_W-1:0]   x_reg, y_reg, ex_reg, ey_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic                       neg_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic signed [POS_W-1:0]    tx_reg, ty_reg;
    logic [DIST_W-1:0]          k_reg, dist_reg;
    logic [CELL_W-1:0]          cx_reg, cy_reg;
    logic                       left_reg, edge_reg;
    logic [MAG2_W-1:0]          m_reg [4];
    logic signed [VEC_W-1:0]    vx0_reg, vx1_reg, vy0_reg, vy1_reg;
    logic signed [VEC_W-1:0]    vax_reg, vay_reg, vbx_reg, vby_reg;
    logic [MAG2_W-1:0]          ma_reg, mb_reg, msel_reg;
    logic                       ppos_reg, ppos2_reg;
    logic [PMAG_W-1:0]          pmag_reg;
    logic [2*PMAG_W-1:0]        psq_reg;
    logic [PROD_W-1:0]          rhs_reg;
    logic                       rneg_reg;
    logic                       done_reg;
    logic [DIST_OUT_W-1:0]      dist_out_reg;
    logic signed [ROW_W-1:0]    ceil_out_reg;
    logic [ROW_W-1:0]           floor_out_reg;
    logic [SHADE_W-1:0]         shade_out_reg;
    logic                       edge_out_reg, left_out_reg;

    logic                       div_start, div_done;
    logic [DIV_NUM_W-1:0]       div_numer, div_q;
    logic [DIV_DEN_W-1:0]       div_denom;

    logic [ANG_W-1:0]           ang;
    logic signed [Z_W-1:0]      z_init;
    logic                       neg_init;
    logic signed [TRIG_W-1:0]   cx_dx, cx_dy;
    logic signed [POS_W-1:0]    tx_n, ty_n;
    logic [DIST_W-1:0]          k_n;
    logic                       out_x, out_y, out_any, hit;
    logic [CELL_W-1:0]          cell_x, cell_y;
    logic signed [VEC_W-1:0]    vx0, vy0;
    logic signed [VEC_W-1:0]    vxs [4];
    logic signed [VEC_W-1:0]    vys [4];
    logic [MAG2_W-1:0]          m_n [4];
    logic [1:0]                 sel_a, sel_b;
    logic signed [VEC_W-1:0]    psel_x, psel_y;
    logic signed [31:0]         p_full;
    logic signed [ROWN_W-1:0]   rn;
    logic [ROWN_W-1:0]          rn_mag;
    logic signed [12:0]         ceil_c, floor_c;
    logic [SHADE_W-1:0]         shade_c;

    grmc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        rn     = ROWN_W'($signed({1'b0, height_reg}))
               * (ROWN_W'($signed({1'b0, dist_reg})) - ROWN_W'(20));
        rn_mag = rn[ROWN_W-1] ? ROWN_W'(-rn) : ROWN_W'(rn);
        div_start = (cmd.op == OP_LOAD) || (cmd.op == OP_DIV_ROW);
        if (cmd.op == OP_LOAD)
        begin
            div_numer = column * fov_reg;
            div_denom = (width_reg == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(width_reg);
        end
        else
        begin
            div_numer = DIV_NUM_W'(rn_mag);
            div_denom = DIV_DEN_W'({dist_reg, 1'b0});
        end
    end

    always_comb
    begin
        ang      = view_reg - {1'b0, fov_reg[FOV_W-1:1]} + div_q[ANG_W-1:0];
        z_init   = {ang[ANG_W-1], ang};
        neg_init = 1'b0;
        if (z_init > 17'sd16384)
        begin
            z_init   = z_init - 17'sd32768;
            neg_init = 1'b1;
        end
        else if (z_init < -17'sd16384)
        begin
            z_init   = z_init + 17'sd32768;
            neg_init = 1'b1;
        end
        cx_dx = y_reg >>> iter_reg;
        cx_dy = x_reg >>> iter_reg;
    end

    always_comb
    begin
        tx_n    = tx_reg + POS_W'(ex_reg);
        ty_n    = ty_reg + POS_W'(ey_reg);
        k_n     = k_reg + 1'b1;
        out_x   = (tx_n <= LIMIT_LO) || (tx_n >= LIMIT_HI);
        out_y   = (ty_n <= LIMIT_LO) || (ty_n >= LIMIT_HI);
        out_any = out_x || out_y;
        cell_x  = cell_of(tx_n);
        cell_y  = cell_of(ty_n);
        hit     = !out_any && map_reg[cell_y][cell_x];
    end

    always_comb
    begin
        vx0 = $signed(VEC_W'({cx_reg, 8'h00})) - $signed(VEC_W'(px_reg));
        vy0 = $signed(VEC_W'({cy_reg, 8'h00})) - $signed(VEC_W'(py_reg));
        for (int i = 0; i < 4; i++)
        begin
            vxs[i] = (i >= 2) ? vx1_reg : vx0_reg;
            vys[i] = (i % 2 == 1) ? vy1_reg : vy0_reg;
        end
        for (int i = 0; i < 4; i++)
        begin
            m_n[i] = MAG2_W'((i >= 2 ? vx0 + 14'sd256 : vx0) * (i >= 2 ? vx0 + 14'sd256 : vx0)
                   + (i % 2 == 1 ? vy0 + 14'sd256 : vy0) * (i % 2 == 1 ? vy0 + 14'sd256 : vy0));
        end
        sel_a = 2'd0;
        for (int i = 1; i < 4; i++)
        begin
            if (m_reg[i] < m_reg[sel_a])
                sel_a = 2'(i);
        end
        sel_b = (sel_a == 2'd0) ? 2'd1 : 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if ((2'(i) != sel_a) && (m_reg[i] < m_reg[sel_b]))
                sel_b = 2'(i);
        end
        psel_x = cmd.corner_sel ? vbx_reg : vax_reg;
        psel_y = cmd.corner_sel ? vby_reg : vay_reg;
        p_full = ex_reg * psel_x + ey_reg * psel_y;
    end

    always_comb
    begin
        ceil_c = rneg_reg ? -$signed({1'b0, div_q[11:0]}) : $signed({1'b0, div_q[11:0]});
        if (ceil_c < -13'sd1024)
            ceil_c = -13'sd1024;
        floor_c = $signed(13'(height_reg)) - ceil_c;
        if (12'(dist_reg) * 12'd4 <= 12'(STEPS_MAX))
            shade_c = SHADE_FULL;
        else if (12'(dist_reg) * 12'd3 <= 12'(STEPS_MAX))
            shade_c = SHADE_DARK;
        else if (12'(dist_reg) * 12'd2 <= 12'(STEPS_MAX))
            shade_c = SHADE_MEDIUM;
        else
            shade_c = SHADE_LIGHT;
        if (edge_reg)
            shade_c = SHADE_BLANK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAP_ROWS; r++)
                map_reg[r] <= '0;
            fov_reg    <= FOV_W'(8192);
            width_reg  <= SWIDTH_W'(120);
            height_reg <= SHEIGHT_W'(40);
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == OP_FINISH);
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MAP_0_3, REG_MAP_4_7, REG_MAP_8_11, REG_MAP_12_15:
                    begin
                        for (int j = 0; j < 4; j++)
                            map_reg[{cfg_index[1:0], 2'(j)}] <= cfg_data[16*j +: 16];
                    end
                    REG_FOV:    fov_reg    <= cfg_data[FOV_W-1:0];
                    REG_WIDTH:  width_reg  <= cfg_data[SWIDTH_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[SHEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                px_reg   <= player_x;
                py_reg   <= player_y;
                view_reg <= view_angle;
                left_reg <= 1'b0;
                edge_reg <= 1'b0;
            end
            OP_ANGLE:
            begin
                z_reg    <= z_init;
                neg_reg  <= neg_init;
                x_reg    <= CORDIC_K;
                y_reg    <= '0;
                iter_reg <= '0;
            end
            OP_CORDIC:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - cx_dx;
                    y_reg <= y_reg + cx_dy;
                    z_reg <= z_reg - $signed(Z_W'(atan_entry(iter_reg)));
                end
                else
                begin
                    x_reg <= x_reg + cx_dx;
                    y_reg <= y_reg - cx_dy;
                    z_reg <= z_reg + $signed(Z_W'(atan_entry(iter_reg)));
                end
                iter_reg <= iter_reg + 1'b1;
            end
            OP_MARCH_INIT:
            begin
                ex_reg <= neg_reg ? -y_reg : y_reg;
                ey_reg <= neg_reg ? -x_reg : x_reg;
                tx_reg <= POS_W'(px_reg * 10'd640);
                ty_reg <= POS_W'(py_reg * 10'd640);
                k_reg  <= '0;
            end
            OP_MARCH:
            begin
                tx_reg   <= tx_n;
                ty_reg   <= ty_n;
                k_reg    <= k_n;
                cx_reg   <= cell_x;
                cy_reg   <= cell_y;
                left_reg <= out_any;
                dist_reg <= hit ? k_n : DIST_W'(STEPS_MAX);
            end
            OP_EDGE_M:
            begin
                vx0_reg <= vx0;
                vx1_reg <= vx0 + 14'sd256;
                vy0_reg <= vy0;
                vy1_reg <= vy0 + 14'sd256;
                for (int i = 0; i < 4; i++)
                    m_reg[i] <= m_n[i];
            end
            OP_EDGE_SEL:
            begin
                vax_reg <= vxs[sel_a];
                vay_reg <= vys[sel_a];
                vbx_reg <= vxs[sel_b];
                vby_reg <= vys[sel_b];
                ma_reg  <= m_reg[sel_a];
                mb_reg  <= m_reg[sel_b];
            end
            OP_EDGE_P:
            begin
                ppos_reg <= (p_full > 0);
                pmag_reg <= p_full[PMAG_W-1:0];
                msel_reg <= cmd.corner_sel ? mb_reg : ma_reg;
            end
            OP_EDGE_SQ:
            begin
                psq_reg   <= pmag_reg * pmag_reg;
                rhs_reg   <= COS2_Q30 * msel_reg;
                ppos2_reg <= ppos_reg;
            end
            OP_EDGE_CMP:
            begin
                edge_reg <= edge_reg || (ppos2_reg && ({psq_reg, 2'b00} > rhs_reg));
            end
            OP_DIV_ROW:
            begin
                rneg_reg <= rn[ROWN_W-1];
            end
            OP_FINISH:
            begin
                dist_out_reg  <= (dist_reg > DIST_W'(255)) ? 8'hFF : DIST_OUT_W'(dist_reg);
                ceil_out_reg  <= ceil_c[ROW_W-1:0];
                floor_out_reg <= floor_c[ROW_W-1:0];
                shade_out_reg <= shade_c;
                edge_out_reg  <= edge_reg;
                left_out_reg  <= left_reg;
            end
            default: ;
        endcase
    end

    assign status.div_done    = div_done;
    assign status.cordic_last = (iter_reg == ITER_W'(CORDIC_ITERS - 1));
    assign status.march_stop  = out_any || hit || (k_n == DIST_W'(STEPS_MAX));
    assign status.march_hit   = hit;

    assign done            = done_reg;
    assign distance_tenths = dist_out_reg;
    assign ceiling_row     = ceil_out_reg;
    assign floor_row       = floor_out_reg;
    assign wall_shade      = shade_out_reg;
    assign on_edge         = edge_out_reg;
    assign left_map        = left_out_reg;

endmodule

`default_nettype wire

[rtl/grmc_ctrl.sv]
// ----------------------------------------------------------------------------
// grmc_ctrl
// Sequencer for one column: angle divide, CORDIC, march, corner test, rows.
// ----------------------------------------------------------------------------
`default_nettype none

module grmc_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    output grmc_pkg::dp_cmd_t         cmd,
    input  wire grmc_pkg::dp_status_t status
);
    import grmc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cmd.op         = OP_NONE;
        cmd.corner_sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DIV_ANG;
                end
            end
            S_DIV_ANG:
            begin
                if (status.div_done)
                    state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                cmd.op     = OP_ANGLE;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.op = OP_CORDIC;
                if (status.cordic_last)
                    state_next = S_MARCH_INIT;
            end
            S_MARCH_INIT:
            begin
                cmd.op     = OP_MARCH_INIT;
                state_next = S_MARCH;
            end
            S_MARCH:
            begin
                cmd.op   = OP_MARCH;
                sel_next = 1'b0;
                if (status.march_stop)
                    state_next = status.march_hit ? S_EDGE_M : S_ROW_START;
            end
            S_EDGE_M:
            begin
                cmd.op     = OP_EDGE_M;
                state_next = S_EDGE_SEL;
            end
            S_EDGE_SEL:
            begin
                cmd.op     = OP_EDGE_SEL;
                state_next = S_EDGE_P;
            end
            S_EDGE_P:
            begin
                cmd.op     = OP_EDGE_P;
                state_next = S_EDGE_SQ;
            end
            S_EDGE_SQ:
            begin
                cmd.op     = OP_EDGE_SQ;
                state_next = S_EDGE_CMP;
            end
            S_EDGE_CMP:
            begin
                cmd.op = OP_EDGE_CMP;
                if (sel_reg)
                    state_next = S_ROW_START;
                else
                begin
                    sel_next   = 1'b1;
                    state_next = S_EDGE_P;
                end
            end
            S_ROW_START:
            begin
                cmd.op     = OP_DIV_ROW;
                state_next = S_DIV_ROW;
            end
            S_DIV_ROW:
            begin
                if (status.div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[rtl/grid_ray_march_column_unit.sv]
// ----------------------------------------------------------------------------
// grid_ray_march_column_unit
// Casts the ray of one screen column across a 16x16 wall bitmap.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  request  | start / busy        | player_x, player_y, view_angle, column
//  result   | done (one cycle)    | distance_tenths, ceiling_row, floor_row,
//           |                     | wall_shade, on_edge, left_map
//  config   | cfg_write           | cfg_index, cfg_data
//
//  A request passes the angle divide, the CORDIC, the march, the corner test
//  when a wall is hit, and the row divide; a ray ends after k steps (k up to
//  10*MAX_DEPTH). The march loop takes one step a cycle; the shared divider
//  serves both divides.
//  Reset clears the map to empty and loads the default view registers.
//  done pulses one cycle with the result; busy falls in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_march_column_unit
#(
    parameter int MAP_SIZE  = grmc_pkg::MAP_SIZE_DEF,
    parameter int MAX_DEPTH = grmc_pkg::MAX_DEPTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [grmc_pkg::POS_IN_W-1:0]   player_x,
    input  wire logic [grmc_pkg::POS_IN_W-1:0]   player_y,
    input  wire logic [grmc_pkg::ANG_W-1:0]      view_angle,
    input  wire logic [grmc_pkg::COL_W-1:0]      column,
    output logic                                 done,
    output logic [grmc_pkg::DIST_OUT_W-1:0]      distance_tenths,
    output logic signed [grmc_pkg::ROW_W-1:0]    ceiling_row,
    output logic [grmc_pkg::ROW_W-1:0]           floor_row,
    output logic [grmc_pkg::SHADE_W-1:0]         wall_shade,
    output logic                                 on_edge,
    output logic                                 left_map,
    input  wire logic                            cfg_write,
    input  wire logic [grmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [grmc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import grmc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    grmc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    grmc_datapath
    #(
        .MAP_SIZE  (MAP_SIZE),
        .MAX_DEPTH (MAX_DEPTH)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .player_x        (player_x),
        .player_y        (player_y),
        .view_angle      (view_angle),
        .column          (column),
        .done            (done),
        .distance_tenths (distance_tenths),
        .ceiling_row     (ceiling_row),
        .floor_row       (floor_row),
        .wall_shade      (wall_shade),
        .on_edge         (on_edge),
        .left_map        (left_map)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("request not taken");

    a_edge_blank: assert property (@(posedge clk) disable iff (!rst_n)
        done && on_edge |-> !left_map && wall_shade == SHADE_BLANK)
        else $error("edge result inconsistent");

    a_left_far: assert property (@(posedge clk) disable iff (!rst_n)
        done && left_map |-> !on_edge && wall_shade != SHADE_BLANK)
        else $error("left map result inconsistent");

endmodule

`default_nettype wire
